// File: sv/vcfgt_pkg.sv
// vcfgt_pkg: types, status codes, character constants and per-byte update
// functions for the genotype classifier; no dependencies
package vcfgt_pkg;

	localparam int unsigned CHAR_W   = 8;
	localparam int unsigned STATUS_W = 4;

	localparam logic [CHAR_W-1:0] CHAR_PIPE  = 8'h7C;
	localparam logic [CHAR_W-1:0] CHAR_SLASH = 8'h2F;
	localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'h2E;
	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_ONE   = 8'h31;
	localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

	localparam logic [1:0] COUNT_SAT = 2'd3;

	typedef enum logic [STATUS_W-1:0] {
		GT_OK          = 4'd0,
		GT_MISSING     = 4'd1,
		GT_UNPHASED    = 4'd2,
		GT_NON_DIPLOID = 4'd3,
		GT_EMPTY       = 4'd4,
		GT_BAD_CHAR    = 4'd5,
		GT_MIXED_SEP   = 4'd6,
		GT_MALFORMED   = 4'd7,
		GT_BAD_INDEX   = 4'd8
	} gt_status_t;

	// per-field scan state; the first token byte is kept only as "is 0" / "is 1"
	typedef struct packed {
		logic       saw_pipe;
		logic       saw_slash;
		logic       bad_char_seen;
		logic       bad_allele_seen;
		logic       missing_seen;
		logic [1:0] allele_count;
		logic [1:0] token_length;
		logic       token_has_dot;
		logic       token_has_digit;
		logic       first_is_zero;
		logic       first_is_one;
		logic [1:0] allele_values;
		logic       allele_index_bad;
	} field_st_t;

	// judge the token that just ended, count it and start a fresh token
	function automatic field_st_t finish_token(input field_st_t st);
		field_st_t r;
		r = st;
		if (st.token_length == 2'd0) begin
			r.bad_allele_seen = 1'b1;
		end else if (st.token_has_dot) begin
			if (st.token_length == 2'd1)
				r.missing_seen = 1'b1;
			else
				r.bad_allele_seen = 1'b1;
		end else if (st.token_has_digit) begin
			if (!(st.token_length == 2'd1 && (st.first_is_zero || st.first_is_one)))
				r.allele_index_bad = 1'b1;
		end
		if (!st.allele_count[1] && st.first_is_one)
			r.allele_values[st.allele_count[0]] = 1'b1;
		if (st.allele_count != COUNT_SAT)
			r.allele_count = st.allele_count + 2'd1;
		r.token_length    = 2'd0;
		r.token_has_dot   = 1'b0;
		r.token_has_digit = 1'b0;
		r.first_is_zero   = 1'b0;
		r.first_is_one    = 1'b0;
		return r;
	endfunction

	// fold one non-empty byte into the field state
	function automatic field_st_t take_byte(input field_st_t st, input logic [CHAR_W-1:0] c);
		field_st_t r;
		r = st;
		if (c == CHAR_PIPE || c == CHAR_SLASH) begin
			if (c == CHAR_PIPE)
				r.saw_pipe = 1'b1;
			else
				r.saw_slash = 1'b1;
			r = finish_token(r);
		end else begin
			if (c >= CHAR_ZERO && c <= CHAR_NINE)
				r.token_has_digit = 1'b1;
			else if (c == CHAR_DOT)
				r.token_has_dot = 1'b1;
			else
				r.bad_char_seen = 1'b1;
			if (st.token_length == 2'd0) begin
				r.first_is_zero = (c == CHAR_ZERO);
				r.first_is_one  = (c == CHAR_ONE);
			end
			if (st.token_length != COUNT_SAT)
				r.token_length = st.token_length + 2'd1;
		end
		return r;
	endfunction

	// status checks in priority order
	function automatic gt_status_t classify(input field_st_t st);
		gt_status_t s;
		if (st.bad_char_seen)
			s = GT_BAD_CHAR;
		else if (st.saw_pipe && st.saw_slash)
			s = GT_MIXED_SEP;
		else if (st.bad_allele_seen)
			s = GT_MALFORMED;
		else if (st.missing_seen)
			s = GT_MISSING;
		else if (st.allele_count != 2'd2)
			s = GT_NON_DIPLOID;
		else if (st.saw_slash)
			s = GT_UNPHASED;
		else if (st.allele_index_bad)
			s = GT_BAD_INDEX;
		else
			s = GT_OK;
		return s;
	endfunction

endpackage

// File: sv/vcfgt_if.sv
// vcfgt channel interfaces: character input and genotype result streams
// depends on vcfgt_pkg for widths
interface vcfgt_char_if;
	logic                          valid;
	logic                          ready;
	logic [vcfgt_pkg::CHAR_W-1:0]  char_byte;
	logic                          last_char;
	logic                          empty_field;

	modport source (output valid, char_byte, last_char, empty_field, input ready);
	modport sink   (input valid, char_byte, last_char, empty_field, output ready);
endinterface

interface vcfgt_result_if;
	logic                           valid;
	logic                           ready;
	logic [vcfgt_pkg::STATUS_W-1:0] gt_status;
	logic                           left_allele;
	logic                           right_allele;

	modport source (output valid, gt_status, left_allele, right_allele, input ready);
	modport sink   (input valid, gt_status, left_allele, right_allele, output ready);
endinterface

// File: sv/vcf_genotype_classifier_core.sv
// vcf_genotype_classifier_core: streaming classifier for VCF GT fields
// depends on vcfgt_pkg and the channel interfaces in vcfgt_if.sv
//
// Takes one GT field character per request on chars and returns one
// classification per field on genotypes, produced by the request that carries
// last_char. A request with empty_field and last_char closes the field as empty
// (status 4); empty_field without last_char is dropped. Throughput is one
// character per cycle unless a closing character stalls; a closing character
// passes through the input register, then the result register. The input register
// keeps taking requests while a finished result waits in the result register, and
// only a closing character stalls when the result register is still full.
module vcf_genotype_classifier_core (
	input  logic                  clk,
	input  logic                  arst_n,
	vcfgt_char_if.sink            chars,
	vcfgt_result_if.source        genotypes
);

	// input register
	logic                             valid_s1;
	logic [vcfgt_pkg::CHAR_W-1:0]     char_s1;
	logic                             last_s1;
	logic                             empty_s1;

	// per-field scan state
	vcfgt_pkg::field_st_t             field_q;

	// result register
	logic                             res_valid_q;
	vcfgt_pkg::gt_status_t            res_status_q;
	logic                             res_left_q;
	logic                             res_right_q;

	logic                             has_result;
	logic                             out_free;
	logic                             advance;
	vcfgt_pkg::field_st_t             st_byte;
	vcfgt_pkg::field_st_t             st_end;
	vcfgt_pkg::gt_status_t            status_end;
	vcfgt_pkg::gt_status_t            status_next;

	// a closing request needs room in the result register
	assign has_result = valid_s1 && last_s1;
	assign out_free   = !res_valid_q || genotypes.ready;
	assign advance    = valid_s1 && (!has_result || out_free);
	assign chars.ready = !valid_s1 || advance;

	// byte update, then the closing token when this is the last byte
	always_comb begin
		st_byte    = vcfgt_pkg::take_byte(field_q, char_s1);
		st_end     = vcfgt_pkg::finish_token(st_byte);
		status_end = vcfgt_pkg::classify(st_end);
		if (empty_s1)
			status_next = vcfgt_pkg::GT_EMPTY;
		else
			status_next = status_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.ready && chars.valid) begin
			char_s1  <= chars.char_byte;
			last_s1  <= chars.last_char;
			empty_s1 <= chars.empty_field;
		end
	end

	// field state: cleared at every field close, untouched by a non-closing empty flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_q <= '0;
		end else if (advance) begin
			if (last_s1)
				field_q <= '0;
			else if (!empty_s1)
				field_q <= st_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && has_result) begin
			res_valid_q <= 1'b1;
		end else if (genotypes.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// alleles are reported only for a supported phased biallelic call
	always_ff @(posedge clk) begin
		if (advance && has_result) begin
			res_status_q <= status_next;
			res_left_q   <= (status_next == vcfgt_pkg::GT_OK) && st_end.allele_values[0];
			res_right_q  <= (status_next == vcfgt_pkg::GT_OK) && st_end.allele_values[1];
		end
	end

	assign genotypes.valid        = res_valid_q;
	assign genotypes.gt_status    = res_status_q;
	assign genotypes.left_allele  = res_left_q;
	assign genotypes.right_allele = res_right_q;

endmodule

// File: sv/vcfgt_checker.sv
// vcfgt_checker: port-level assertions for vcf_genotype_classifier_core
// depends on vcfgt_pkg; bound into vcf_genotype_classifier_core at the end of this file
module vcfgt_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic [vcfgt_pkg::STATUS_W-1:0] gt_status,
	input logic                           left_allele,
	input logic                           right_allele
);

	// a stalled result stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// a stalled result keeps its payload
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(gt_status) && $stable(left_allele)
			&& $stable(right_allele))
		else $error("result changed while stalled");

	// only defined status codes leave the block
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> gt_status <= vcfgt_pkg::STATUS_W'(vcfgt_pkg::GT_BAD_INDEX))
		else $error("undefined status code");

	// alleles are zero for any status other than ok
	a_alleles_gated: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && gt_status != vcfgt_pkg::STATUS_W'(vcfgt_pkg::GT_OK)
			|-> !left_allele && !right_allele)
		else $error("alleles reported with failing status");

endmodule

bind vcf_genotype_classifier_core vcfgt_checker u_vcfgt_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (genotypes.valid),
	.out_ready    (genotypes.ready),
	.gt_status    (genotypes.gt_status),
	.left_allele  (genotypes.left_allele),
	.right_allele (genotypes.right_allele)
);
